>>> design/ablc_pkg.sv
package ablc_pkg;

  typedef logic signed [9:0] axis_t;

  typedef enum logic [1:0] {
    ACT_NORMAL = 2'd0,
    ACT_BRAKE  = 2'd1,
    ACT_DIM    = 2'd2
  } act_e;

  typedef enum logic [2:0] {
    CFG_BLOCK_ENABLE  = 3'd0,
    CFG_TRAVEL_SEL    = 3'd1,
    CFG_VERT_SEL      = 3'd2,
    CFG_INVERT_TRAVEL = 3'd3,
    CFG_ENGAGE_THR    = 3'd4,
    CFG_DISENGAGE_THR = 3'd5,
    CFG_SUSTAIN_MS    = 3'd6,
    CFG_SIDEWAYS_EN   = 3'd7
  } cfg_idx_e;

  localparam int unsigned MaxActs = 3;

  localparam logic [31:0]        RecalcGapMs    = 32'd30;
  localparam logic [31:0]        SidewaysDimMs  = 32'd5000;
  localparam logic signed [10:0] VertLow        = -11'sd50;
  localparam logic signed [10:0] VertHigh       = 11'sd50;
  localparam logic signed [10:0] SidewaysTravel = 11'sd200;
  localparam logic [7:0]         BrakePreset    = 8'd2;

  typedef struct packed {
    logic        block_enable;
    logic [1:0]  travel_sel;
    logic [1:0]  vert_sel;
    logic        invert_travel;
    axis_t       engage_thr;
    axis_t       disengage_thr;
    logic [15:0] sustain_ms;
    logic        sideways_en;
  } cfg_t;

  typedef struct packed {
    logic [31:0] recalc_time;
    logic [31:0] brake_time;
    logic [31:0] sideways_time;
    logic        sideways;
    logic        braking;
    axis_t [2:0] axis;
  } st_t;

  typedef struct packed {
    logic [31:0]     now_ms;
    logic            display_busy;
    logic            sample_valid;
    logic [2:0][7:0] low_byte;
    logic [2:0][7:0] high_byte;
    logic [7:0]      current_preset;
    logic            brightness_nonzero;
  } tick_t;

  typedef struct packed {
    logic [1:0]         cnt;
    act_e [MaxActs-1:0] acts;
    st_t                st;
  } eval_res_t;

endpackage

>>> design/ablc_eval.sv
module ablc_eval import ablc_pkg::*; (
  input  tick_t     tick_i,
  input  cfg_t      cfg_i,
  input  st_t       st_i,
  output eval_res_t res_o
);

  logic [31:0]        brake_gap, recalc_gap, side_gap;
  logic               en, is_brake, bright;
  logic               release_hit, recalc_hit, side_hit;
  axis_t [2:0]        axis_new;
  axis_t              travel_pick, vert_pick;
  logic signed [10:0] travel, vert, engage, disengage;

  // candidate emissions in model order: release, branch first, branch second
  logic [MaxActs-1:0] emit_v;
  act_e [MaxActs-1:0] emit_a;
  logic [1:0]         cnt;
  act_e [MaxActs-1:0] acts;
  st_t                st_d;

  function automatic axis_t pick_axis(axis_t [2:0] ax, logic [1:0] sel);
    axis_t r;
    case (sel)
      2'd0:    r = ax[0];
      2'd1:    r = ax[1];
      default: r = ax[2];
    endcase
    return r;
  endfunction

  assign en       = cfg_i.block_enable && !tick_i.display_busy;
  assign is_brake = (tick_i.current_preset == BrakePreset);
  assign bright   = tick_i.brightness_nonzero;

  assign brake_gap  = tick_i.now_ms - st_i.brake_time;
  assign recalc_gap = tick_i.now_ms - st_i.recalc_time;
  assign side_gap   = tick_i.now_ms - st_i.sideways_time;

  assign release_hit = (brake_gap > {16'd0, cfg_i.sustain_ms}) && is_brake;
  assign recalc_hit  = (recalc_gap > RecalcGapMs);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      axis_new[i] = tick_i.sample_valid ?
                    axis_t'({tick_i.high_byte[i], tick_i.low_byte[i][7:6]}) : st_i.axis[i];
    end
  end

  assign travel_pick = pick_axis(axis_new, cfg_i.travel_sel);
  assign vert_pick   = pick_axis(axis_new, cfg_i.vert_sel);

  // 11 bits so that negating -512 stays exact
  assign travel    = cfg_i.invert_travel ? -11'(travel_pick) : 11'(travel_pick);
  assign vert      = 11'(vert_pick);
  assign engage    = 11'(cfg_i.engage_thr);
  assign disengage = 11'(cfg_i.disengage_thr);

  assign side_hit = (vert > VertLow) && (vert < VertHigh) &&
                    (travel > SidewaysTravel) && cfg_i.sideways_en;

  always_comb begin
    st_d   = st_i;
    emit_v = '0;
    emit_a = '{default: ACT_NORMAL};
    if (en) begin
      emit_v[0] = release_hit;
      if (recalc_hit) begin
        st_d.axis = axis_new;
        if (side_hit) begin
          if (is_brake) begin
            emit_v[1] = 1'b1;
          end else if (!st_i.sideways) begin
            st_d.sideways_time = tick_i.now_ms;
            st_d.sideways      = 1'b1;
          end else if ((side_gap > SidewaysDimMs) && bright) begin
            emit_v[1] = 1'b1;
            emit_a[1] = ACT_DIM;
          end
          st_d.recalc_time = tick_i.now_ms;
        end else begin
          emit_v[1]     = st_i.sideways && !bright && cfg_i.sideways_en;
          st_d.sideways = 1'b0;
          if (travel < engage) begin
            st_d.braking = 1'b0;
            emit_v[2]    = is_brake && (travel < disengage);
          end else begin
            st_d.brake_time = tick_i.now_ms;
            if (!st_i.braking) begin
              st_d.braking = 1'b1;
              emit_v[2]    = 1'b1;
              emit_a[2]    = ACT_BRAKE;
            end
          end
        end
      end
    end
  end

  // pack the valid candidates to the front
  always_comb begin
    cnt  = 2'd0;
    acts = '{default: ACT_NORMAL};
    for (int k = 0; k < MaxActs; k++) begin
      if (emit_v[k]) begin
        acts[cnt] = emit_a[k];
        cnt       = cnt + 2'd1;
      end
    end
  end

  assign res_o.cnt  = cnt;
  assign res_o.acts = acts;
  assign res_o.st   = st_d;

endmodule

>>> design/accel_brake_light_controller.sv
// A tick transferred into the input register has its actions evaluated combinationally and
// loaded into the action queue when the queue drains. Throughput: one tick per cycle while
// each tick yields at most one action and the receiver does not stall; further ticks wait.
// The rate is set by the three-entry action queue, which drains one action per unstalled cycle.
// Reset clears all timers, flags and axis values and loads the register defaults.
module accel_brake_light_controller import ablc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] now_ms_i,
  input  logic        display_busy_i,
  input  logic        sample_valid_i,
  input  logic [7:0]  x_low_byte_i,
  input  logic [7:0]  x_high_byte_i,
  input  logic [7:0]  y_low_byte_i,
  input  logic [7:0]  y_high_byte_i,
  input  logic [7:0]  z_low_byte_i,
  input  logic [7:0]  z_high_byte_i,
  input  logic [7:0]  current_preset_i,
  input  logic        brightness_nonzero_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic        last_action_o
);

  cfg_t               cfg_q, cfg_d;
  st_t                st_q;
  tick_t              tick_q;
  logic               tick_vld_q, tick_vld_d;
  act_e [MaxActs-1:0] act_q, act_d;
  logic [1:0]         cnt_q, cnt_d;
  eval_res_t          res;
  logic               in_xfer, out_xfer, buf_free, consume;

  // ---------------- configuration ----------------
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BLOCK_ENABLE:  cfg_d.block_enable  = cfg_data_i[0];
        CFG_TRAVEL_SEL:    cfg_d.travel_sel    = cfg_data_i[1:0];
        CFG_VERT_SEL:      cfg_d.vert_sel      = cfg_data_i[1:0];
        CFG_INVERT_TRAVEL: cfg_d.invert_travel = cfg_data_i[0];
        CFG_ENGAGE_THR:    cfg_d.engage_thr    = axis_t'(cfg_data_i[9:0]);
        CFG_DISENGAGE_THR: cfg_d.disengage_thr = axis_t'(cfg_data_i[9:0]);
        CFG_SUSTAIN_MS:    cfg_d.sustain_ms    = cfg_data_i;
        CFG_SIDEWAYS_EN:   cfg_d.sideways_en   = cfg_data_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_enable  <= 1'b1;
      cfg_q.travel_sel    <= 2'd2;
      cfg_q.vert_sel      <= 2'd0;
      cfg_q.invert_travel <= 1'b1;
      cfg_q.engage_thr    <= 10'sd60;
      cfg_q.disengage_thr <= -10'sd20;
      cfg_q.sustain_ms    <= 16'd2500;
      cfg_q.sideways_en   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------- handshakes ----------------
  assign out_valid_o   = (cnt_q != 2'd0);
  assign action_o      = act_q[0];
  assign last_action_o = (cnt_q == 2'd1);

  assign out_xfer = out_valid_o && !out_stall_i;
  // the queue can take a fresh tick's actions once it drains this cycle
  assign buf_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_xfer);
  assign consume  = tick_vld_q && buf_free;

  assign in_stall_o = tick_vld_q && !buf_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // ---------------- input register ----------------
  assign tick_vld_d = in_xfer ? 1'b1 : (consume ? 1'b0 : tick_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_vld_q <= 1'b0;
    end else begin
      tick_vld_q <= tick_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tick_q.now_ms             <= now_ms_i;
      tick_q.display_busy       <= display_busy_i;
      tick_q.sample_valid       <= sample_valid_i;
      tick_q.low_byte           <= {z_low_byte_i, y_low_byte_i, x_low_byte_i};
      tick_q.high_byte          <= {z_high_byte_i, y_high_byte_i, x_high_byte_i};
      tick_q.current_preset     <= current_preset_i;
      tick_q.brightness_nonzero <= brightness_nonzero_i;
    end
  end

  // ---------------- evaluation ----------------
  ablc_eval u_eval (
    .tick_i (tick_q),
    .cfg_i  (cfg_q),
    .st_i   (st_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (consume) begin
      st_q <= res.st;
    end
  end

  // ---------------- action queue ----------------
  always_comb begin
    act_d = act_q;
    cnt_d = cnt_q;
    if (consume) begin
      act_d = res.acts;
      cnt_d = res.cnt;
    end else if (out_xfer) begin
      act_d[0] = act_q[1];
      act_d[1] = act_q[2];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
  end

  // ---------------- assertions ----------------
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      out_valid_o && $stable(action_o) && $stable(last_action_o))
    else $error("stalled action changed");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_vld_q && (cnt_q >= 2'd2)) |-> in_stall_o)
    else $error("tick taken while queue holds more than one action");

  a_disabled_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && !cfg_q.block_enable) |=> (cnt_q == 2'd0) && $stable(st_q))
    else $error("disabled block produced actions or changed state");

  a_brake_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(st_q.braking) |->
      (cnt_q != 2'd0) && ((act_q[0] == ACT_BRAKE) || (act_q[1] == ACT_BRAKE) ||
                          (act_q[2] == ACT_BRAKE)))
    else $error("braking engaged without a brake action");

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_vld_q |-> !in_stall_o)
    else $error("stall raised with empty input register");

endmodule

>>> tb/tb.sv
module tb;
  import ablc_pkg::*;

  localparam int CycleLimit   = 250000;
  localparam int SettleCycles = 8;

  typedef struct {
    act_e act;
    logic last;
  } act_exp_t;

  typedef enum {MOT_QUIET, MOT_BRAKE, MOT_SIDE, MOT_REVERSE, MOT_NOISE} motion_e;

  // Predicts the actions of each tick and checks them against the outputs.
  class brake_scoreboard;
    cfg_t        cfg;
    logic [31:0] recalc_time;
    logic [31:0] brake_time;
    logic [31:0] sideways_time;
    logic        sideways;
    logic        braking;
    axis_t       axis_val [3];
    act_exp_t    exp_q [$];
    int          errors;
    int          n_ticks;
    int          n_checked;
    int          act_count [3];

    function new();
      cfg.block_enable  = 1'b1;
      cfg.travel_sel    = 2'd2;
      cfg.vert_sel      = 2'd0;
      cfg.invert_travel = 1'b1;
      cfg.engage_thr    = 10'sd60;
      cfg.disengage_thr = -10'sd20;
      cfg.sustain_ms    = 16'd2500;
      cfg.sideways_en   = 1'b1;
      recalc_time   = '0;
      brake_time    = '0;
      sideways_time = '0;
      sideways      = 1'b0;
      braking       = 1'b0;
      axis_val      = '{default: '0};
      errors        = 0;
      n_ticks       = 0;
      n_checked     = 0;
      act_count     = '{default: 0};
    endfunction

    // selector value three falls through to z
    static function int axis_slot(logic [1:0] sel);
      return (sel == 2'd0) ? 0 : (sel == 2'd1) ? 1 : 2;
    endfunction

    function int pending();
      return exp_q.size();
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] val);
      case (idx)
        CFG_BLOCK_ENABLE:  cfg.block_enable  = val[0];
        CFG_TRAVEL_SEL:    cfg.travel_sel    = val[1:0];
        CFG_VERT_SEL:      cfg.vert_sel      = val[1:0];
        CFG_INVERT_TRAVEL: cfg.invert_travel = val[0];
        CFG_ENGAGE_THR:    cfg.engage_thr    = val[9:0];
        CFG_DISENGAGE_THR: cfg.disengage_thr = val[9:0];
        CFG_SUSTAIN_MS:    cfg.sustain_ms    = val;
        CFG_SIDEWAYS_EN:   cfg.sideways_en   = val[0];
        default: ;
      endcase
    endfunction

    function void note_tick(tick_t t);
      act_e        acts [$];
      act_exp_t    e;
      logic        brk;
      logic [31:0] since_brake;
      logic [31:0] since_recalc;
      logic [31:0] since_side;
      int          trv;
      int          vrt;
      int          i;
      n_ticks++;
      if (!cfg.block_enable || t.display_busy) return;
      brk          = (t.current_preset == BrakePreset);
      since_brake  = t.now_ms - brake_time;
      since_recalc = t.now_ms - recalc_time;
      since_side   = t.now_ms - sideways_time;
      if (since_brake > {16'd0, cfg.sustain_ms} && brk) acts.push_back(ACT_NORMAL);
      if (since_recalc > RecalcGapMs) begin
        // an invalid sample leaves the stored axes as they were
        if (t.sample_valid) begin
          for (i = 0; i < 3; i++) axis_val[i] = {t.high_byte[i], t.low_byte[i][7:6]};
        end
        trv = axis_val[axis_slot(cfg.travel_sel)];
        vrt = axis_val[axis_slot(cfg.vert_sel)];
        if (cfg.invert_travel) trv = -trv;  // -512 becomes +512, kept at full width
        if (vrt > int'(VertLow) && vrt < int'(VertHigh) && trv > int'(SidewaysTravel) &&
            cfg.sideways_en) begin
          if (brk) begin
            acts.push_back(ACT_NORMAL);
          end else if (!sideways) begin
            sideways_time = t.now_ms;
            sideways      = 1'b1;
          end else if (since_side > SidewaysDimMs && t.brightness_nonzero) begin
            acts.push_back(ACT_DIM);
          end
          recalc_time = t.now_ms;
        end else begin
          if (sideways && !t.brightness_nonzero && cfg.sideways_en) acts.push_back(ACT_NORMAL);
          sideways = 1'b0;
          if (trv < int'($signed(cfg.engage_thr))) begin
            braking = 1'b0;
            if (brk && trv < int'($signed(cfg.disengage_thr))) acts.push_back(ACT_NORMAL);
          end else begin
            brake_time = t.now_ms;
            if (!braking) begin
              braking = 1'b1;
              acts.push_back(ACT_BRAKE);
            end
          end
        end
      end
      for (i = 0; i < acts.size() && i < MaxActs; i++) begin
        e.act  = acts[i];
        e.last = (i == acts.size() - 1);
        exp_q.push_back(e);
      end
    endfunction

    function void check_action(logic [1:0] act, logic last);
      act_exp_t e;
      n_checked++;
      if (act < 2'd3) act_count[act]++;
      if (exp_q.size() == 0) begin
        errors++;
        $display("%0t: action %0d last %0b with nothing expected", $time, act, last);
        return;
      end
      e = exp_q.pop_front();
      if (act !== e.act) begin
        errors++;
        $display("%0t: action expected %0d actual %0d", $time, e.act, act);
      end
      if (last !== e.last) begin
        errors++;
        $display("%0t: last_action expected %0b actual %0b", $time, e.last, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_idx_e    cfg_index = CFG_BLOCK_ENABLE;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] now_ms = '0;
  logic        display_busy = 1'b0;
  logic        sample_valid = 1'b0;
  logic [7:0]  x_low = '0, x_high = '0;
  logic [7:0]  y_low = '0, y_high = '0;
  logic [7:0]  z_low = '0, z_high = '0;
  logic [7:0]  current_preset = '0;
  logic        brightness_nonzero = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  action;
  logic        last_action;

  brake_scoreboard sb = new();
  logic [31:0]     clock_ms = '0;
  bit              send_gaps = 1'b1;
  bit              recv_gaps = 1'b1;
  int              cycles = 0;
  int              n_settings = 0;

  accel_brake_light_controller dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .now_ms_i            (now_ms),
    .display_busy_i      (display_busy),
    .sample_valid_i      (sample_valid),
    .x_low_byte_i        (x_low),
    .x_high_byte_i       (x_high),
    .y_low_byte_i        (y_low),
    .y_high_byte_i       (y_high),
    .z_low_byte_i        (z_low),
    .z_high_byte_i       (z_high),
    .current_preset_i    (current_preset),
    .brightness_nonzero_i(brightness_nonzero),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .action_o            (action),
    .last_action_o       (last_action)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d actions outstanding", cycles, sb.pending());
      $display("accel_brake_light_controller: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_action(action, last_action);
  end

  // receiver: random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (recv_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic tick_t mk_tick(logic [31:0] now_v, logic busy, logic valid,
                                    int x, int y, int z, logic [7:0] preset, logic bright);
    tick_t      t;
    int         a [3];
    logic [9:0] v;
    int         i;
    a = '{x, y, z};
    t.now_ms             = now_v;
    t.display_busy       = busy;
    t.sample_valid       = valid;
    t.current_preset     = preset;
    t.brightness_nonzero = bright;
    for (i = 0; i < 3; i++) begin
      v = a[i][9:0];
      t.high_byte[i] = v[9:2];
      t.low_byte[i]  = {v[1:0], 6'($urandom)};
    end
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    in_valid           <= 1'b1;
    now_ms             <= t.now_ms;
    display_busy       <= t.display_busy;
    sample_valid       <= t.sample_valid;
    x_low              <= t.low_byte[0];
    x_high             <= t.high_byte[0];
    y_low              <= t.low_byte[1];
    y_high             <= t.high_byte[1];
    z_low              <= t.low_byte[2];
    z_high             <= t.high_byte[2];
    current_preset     <= t.current_preset;
    brightness_nonzero <= t.brightness_nonzero;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(t);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic dtick(input logic [31:0] step, input logic busy, input logic valid,
                       input int x, input int y, input int z,
                       input logic [7:0] preset, input logic bright);
    clock_ms += step;
    send_tick(mk_tick(clock_ms, busy, valid, x, y, z, preset, bright));
  endtask

  // hold off the sender until every outstanding action has come back
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apply_cfg(input logic en, input logic [1:0] tsel, input logic [1:0] vsel,
                           input logic inv, input int eng, input int dis, input int sus,
                           input logic sw);
    logic [15:0] vals [8];
    int          i;
    vals[CFG_BLOCK_ENABLE]  = {15'd0, en};
    vals[CFG_TRAVEL_SEL]    = {14'd0, tsel};
    vals[CFG_VERT_SEL]      = {14'd0, vsel};
    vals[CFG_INVERT_TRAVEL] = {15'd0, inv};
    vals[CFG_ENGAGE_THR]    = {6'd0, 10'(eng)};
    vals[CFG_DISENGAGE_THR] = {6'd0, 10'(dis)};
    vals[CFG_SUSTAIN_MS]    = 16'(sus);
    vals[CFG_SIDEWAYS_EN]   = {15'd0, sw};
    for (i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_e'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(cfg_idx_e'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [31:0] next_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return $urandom;                       // arbitrary jump, wraps too
    if (r < 12) return $urandom_range(0, 30);         // inside the recalc gap
    if (r < 20) return $urandom_range(5001, 9000);    // past the dim delay
    if (r < 26) return $urandom_range(2000, 70000);   // around sustain times
    return $urandom_range(31, 400);
  endfunction

  function automatic tick_t random_tick(logic [31:0] now_v, motion_e kind);
    int         ax [3];
    int         ts;
    int         vs;
    int         te;
    int         raw;
    int         r;
    logic [7:0] preset;
    int         i;
    ts = brake_scoreboard::axis_slot(sb.cfg.travel_sel);
    vs = brake_scoreboard::axis_slot(sb.cfg.vert_sel);
    for (i = 0; i < 3; i++) ax[i] = int'($urandom_range(0, 1023)) - 512;
    te = 0;
    case (kind)
      MOT_SIDE: begin
        ax[vs] = int'($urandom_range(0, 98)) - 49;
        te     = $urandom_range(201, 512);
      end
      MOT_BRAKE:   te = int'($signed(sb.cfg.engage_thr)) + int'($urandom_range(0, 40));
      MOT_QUIET:   te = int'($urandom_range(0, 80)) - 40;
      MOT_REVERSE: te = int'($signed(sb.cfg.disengage_thr)) - int'($urandom_range(1, 60));
      default: ;
    endcase
    if (kind != MOT_NOISE) begin
      raw = sb.cfg.invert_travel ? -te : te;
      if (raw > 511) raw = 511;
      if (raw < -512) raw = -512;
      ax[ts] = raw;
    end
    r = $urandom_range(0, 99);
    preset = (r < 45) ? BrakePreset : (r < 90) ? 8'd1 : 8'($urandom);
    return mk_tick(now_v, $urandom_range(0, 11) == 0, $urandom_range(0, 7) != 0,
                   ax[0], ax[1], ax[2], preset, 1'($urandom));
  endfunction

  task automatic random_ticks(input int count);
    motion_e kind;
    int      left;
    int      r;
    int      i;
    kind = MOT_QUIET;
    left = 0;
    for (i = 0; i < count; i++) begin
      // motions come in runs so sideways and braking sequences build up
      if (left == 0) begin
        r = $urandom_range(0, 99);
        kind = (r < 30) ? MOT_SIDE : (r < 55) ? MOT_BRAKE : (r < 75) ? MOT_QUIET :
               (r < 88) ? MOT_REVERSE : MOT_NOISE;
        left = $urandom_range(1, 10);
      end
      left--;
      clock_ms += next_step();
      send_tick(random_tick(clock_ms, kind));
      if ($urandom_range(0, 60) == 0) drain(1);
    end
  endtask

  task automatic directed_ticks();
    tick_t t;
    // reset settings: travel on z, inverted, vertical on x
    dtick(0, 0, 1, 0, 0, 0, 1, 1);
    dtick(100, 1, 1, 0, 0, -100, 1, 1);        // busy, ignored
    dtick(0, 0, 1, 0, 0, -100, 1, 1);          // engage
    dtick(50, 0, 1, 0, 0, -100, BrakePreset, 1);
    dtick(40, 0, 1, 0, 0, 50, BrakePreset, 1); // below disengage
    dtick(3000, 0, 0, 0, 0, 0, BrakePreset, 1); // sustain ran out, stale sample
    dtick(100, 0, 1, 10, 0, -300, 1, 1);       // wheel on its side
    dtick(10, 0, 1, 10, 0, -300, 1, 1);
    dtick(31, 0, 1, 10, 0, -300, 1, 1);
    dtick(5001, 0, 1, 10, 0, -300, 1, 1);      // dim
    dtick(40, 0, 1, 10, 0, -300, BrakePreset, 1);
    dtick(40, 0, 1, 10, 0, -300, 1, 0);
    dtick(3000, 0, 1, 300, 0, -400, BrakePreset, 0); // release, upright, engage
    dtick(40, 0, 1, 10, 5, -300, 1, 1);
    dtick(30, 0, 1, 10, 5, -300, 1, 1);        // gap of exactly 30: no recalc
    dtick(1, 0, 1, 10, 5, -300, 1, 1);
    clock_ms += 40;
    t = mk_tick(clock_ms, 0, 1, 0, 0, 0, 8'hFF, 1);
    t.low_byte  = '1;
    t.high_byte = '1;
    send_tick(t);
    clock_ms += 40;
    t = mk_tick(clock_ms, 0, 1, 0, 0, 0, 8'h00, 0);
    t.low_byte  = '0;
    t.high_byte = {3{8'h80}};
    send_tick(t);
    clock_ms += 40;
    t = mk_tick(clock_ms, 0, 1, 0, 0, 0, BrakePreset, 1);
    t.low_byte  = '1;
    t.high_byte = {3{8'h7F}};
    send_tick(t);
    clock_ms = 32'hFFFF_FFF0;
    dtick(0, 0, 1, 0, 0, -200, 1, 1);
    dtick(32, 0, 1, 0, 0, 100, BrakePreset, 1); // time wraps
    clock_ms = 32'hFFFF_FFFF;
    dtick(0, 0, 1, 0, 0, 0, 8'hA5, 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_ticks();
    drain(SettleCycles);

    apply_cfg(1, 2, 0, 1, 60, -20, 2500, 1);
    random_ticks(42);
    drain(SettleCycles);

    send_gaps = 1'($urandom_range(0, 1));
    apply_cfg(1, 0, 1, 0, 100, -100, 0, 1);
    random_ticks(42);
    drain(SettleCycles);

    recv_gaps = 1'($urandom_range(0, 1));
    send_gaps = 1'b1;
    apply_cfg(1, 1, 2, 1, -512, -512, 65535, 1);
    random_ticks(42);
    drain(SettleCycles);

    recv_gaps = 1'b1;
    apply_cfg(1, 2, 0, 1, 511, 511, 300, 1);
    dtick(100, 0, 1, 300, 0, -512, 1, 1);      // inverted -512 becomes +512, above the 511 threshold
    random_ticks(40);
    drain(SettleCycles);

    apply_cfg(1, 3, 1, 1, 30, 0, 1000, 0);
    random_ticks(42);
    drain(SettleCycles);

    apply_cfg(0, 1, 2, 0, 0, 0, 0, 0);         // block off
    random_ticks(25);
    drain(SettleCycles);

    repeat (2) begin
      apply_cfg(1, 2'($urandom_range(0, 2)), 2'($urandom_range(0, 2)), 1'($urandom),
                int'($urandom_range(0, 1023)) - 512, int'($urandom_range(0, 1023)) - 512,
                int'($urandom_range(0, 4000)), 1);
      random_ticks(42);
      drain(SettleCycles);
    end

    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    apply_cfg(1, 2, 0, 1, 60, -20, 2500, 1);
    random_ticks(42);
    drain(SettleCycles);

    $display("%0d ticks over %0d register settings; %0d actions checked", sb.n_ticks,
             n_settings, sb.n_checked);
    $display("normal %0d, brake %0d, dim %0d", sb.act_count[0], sb.act_count[1],
             sb.act_count[2]);
    if (sb.errors == 0) begin
      $display("accel_brake_light_controller: match");
    end else begin
      $display("accel_brake_light_controller: mismatch");
    end
    $finish;
  end

endmodule
